[rtl/core/smac_pkg.sv]
// shared widths, register indexes and reset values of the sonar average block
package smac_pkg;

  localparam int unsigned SONAR_W = 16;
  localparam int unsigned MAG_W   = 32;
  localparam int unsigned MAGN_W  = 31;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned PADDR_W = 3;

  // register indexes, taken from paddr[2]
  typedef enum logic [0:0] {
    REG_CLAMP_LOW  = 1'b0,
    REG_CLAMP_HIGH = 1'b1
  } reg_idx_e;

  localparam logic [SONAR_W-1:0] CLAMP_LOW_RST  = 16'd0;
  localparam logic [SONAR_W-1:0] CLAMP_HIGH_RST = 16'd2500;

  localparam logic [MAGN_W-1:0] MAGN_MAX = {MAGN_W{1'b1}};

endpackage

[rtl/core/smac_if.sv]
// valid/ready channels for sensor items and filtered result items
interface smac_in_if;
  import smac_pkg::*;

  logic               valid;
  logic               ready;
  logic [SONAR_W-1:0] sonar_left_mm;
  logic [SONAR_W-1:0] sonar_right_mm;
  logic signed [MAG_W-1:0] mag_left;
  logic signed [MAG_W-1:0] mag_right;

  modport source (output valid, sonar_left_mm, sonar_right_mm, mag_left, mag_right,
                  input ready);
  modport sink (input valid, sonar_left_mm, sonar_right_mm, mag_left, mag_right,
                output ready);
endinterface

interface smac_out_if;
  import smac_pkg::*;

  logic               valid;
  logic               ready;
  logic [SONAR_W-1:0] sonar_left_avg_mm;
  logic [SONAR_W-1:0] sonar_right_avg_mm;
  logic               side_left;
  logic [MAGN_W-1:0]  magnitude_left;
  logic               side_right;
  logic [MAGN_W-1:0]  magnitude_right;

  modport source (output valid, sonar_left_avg_mm, sonar_right_avg_mm, side_left,
                  magnitude_left, side_right, magnitude_right,
                  input ready);
  modport sink (input valid, sonar_left_avg_mm, sonar_right_avg_mm, side_left,
                magnitude_left, side_right, magnitude_right,
                output ready);
endinterface

[rtl/core/sonar_moving_average_clamp.sv]
// top level: sonar window mean with clamp, magnetic side and magnitude
//
// Takes one sensor item per clock while ready is high and returns one result
// item per item via stage 1 (ram read), stage 2 (running-sum update) and the
// output register (reciprocal multiply and clamp). Each sonar channel keeps its
// last WINDOW_LEN samples in one shared ring ram, read at the write pointer on
// acceptance; the window sums are kept as running sums, and the divide by
// WINDOW_LEN is an exact multiply by a rounded-up reciprocal. The rings read as
// zero until the pointer first wraps, so no clearing pass runs after reset. Ready
// drops only while the output register and both inner stages are full and the
// sink stalls. Clamp limits are written over an APB port at byte addresses 0
// (low) and 4 (high); when low exceeds high the result is the low limit.
module sonar_moving_average_clamp #(
  parameter int unsigned WINDOW_LEN = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [smac_pkg::PADDR_W-1:0]  paddr,
  input  logic [smac_pkg::DATA_W-1:0]   pwdata,
  output logic [smac_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  smac_in_if.sink                       item_i,
  smac_out_if.source                    result_o
);
  import smac_pkg::*;

  localparam int unsigned PTR_W     = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int unsigned SUM_W     = $clog2(WINDOW_LEN * 65535 + 1);
  localparam int unsigned DIV_SHIFT = SUM_W + $clog2(WINDOW_LEN);
  localparam longint unsigned DIV_SCALE = 64'd1 << DIV_SHIFT;
  localparam longint unsigned RECIP_M   = (DIV_SCALE + WINDOW_LEN - 1) / WINDOW_LEN;
  localparam int unsigned RECIP_W   = $clog2(RECIP_M + 1);
  localparam int unsigned PROD_W    = SUM_W + RECIP_W;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW_LEN - 1);

  // configuration registers
  logic [SONAR_W-1:0] clamp_low_q, clamp_high_q;
  logic               cfg_wr;
  reg_idx_e           cfg_idx;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clamp_low_q  <= CLAMP_LOW_RST;
      clamp_high_q <= CLAMP_HIGH_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_CLAMP_LOW:  clamp_low_q  <= pwdata[SONAR_W-1:0];
        REG_CLAMP_HIGH: clamp_high_q <= pwdata[SONAR_W-1:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (cfg_idx)
      REG_CLAMP_LOW:  prdata = DATA_W'(clamp_low_q);
      REG_CLAMP_HIGH: prdata = DATA_W'(clamp_high_q);
      default:        prdata = '0;
    endcase
  end

  // pipeline flow control
  logic s1_valid_q, s2_valid_q, out_valid_q;
  logic out_en, s2_en, s1_en, accept, commit;

  assign out_en = !out_valid_q || result_o.ready;
  assign s2_en  = !s2_valid_q || out_en;
  assign s1_en  = !s1_valid_q || s2_en;
  assign accept = item_i.valid && s1_en;
  assign commit = s1_valid_q && s2_en;
  assign item_i.ready = s1_en;

  // ring write pointer and first-wrap flag
  logic [PTR_W-1:0] ptr_q;
  logic             wrapped_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q     <= '0;
      wrapped_q <= 1'b0;
    end else if (accept) begin
      if (ptr_q == PTR_LAST) begin
        ptr_q     <= '0;
        wrapped_q <= 1'b1;
      end else begin
        ptr_q <= ptr_q + PTR_W'(1);
      end
    end
  end

  // stage 1: item register, aligned with the ring read data
  logic [SONAR_W-1:0] s1_left_q, s1_right_q, fwd_left_q, fwd_right_q;
  logic [MAG_W-1:0]   s1_mag_l_q, s1_mag_r_q;
  logic [PTR_W-1:0]   s1_ptr_q;
  logic               s1_seen_q, s1_fwd_q;
  logic [2*SONAR_W-1:0] ring_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_fwd_q   <= 1'b0;
    end else if (s1_en) begin
      s1_valid_q <= item_i.valid;
      // same slot still being written by the leaving item (one-entry window)
      s1_fwd_q   <= commit && (s1_ptr_q == ptr_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_left_q   <= item_i.sonar_left_mm;
      s1_right_q  <= item_i.sonar_right_mm;
      s1_mag_l_q  <= item_i.mag_left;
      s1_mag_r_q  <= item_i.mag_right;
      s1_ptr_q    <= ptr_q;
      s1_seen_q   <= wrapped_q;
      fwd_left_q  <= s1_left_q;
      fwd_right_q <= s1_right_q;
    end
  end

  smac_ram #(
    .WIDTH (2 * SONAR_W),
    .DEPTH (WINDOW_LEN)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (commit),
    .waddr_i (s1_ptr_q),
    .wdata_i ({s1_left_q, s1_right_q}),
    .re_i    (accept),
    .raddr_i (ptr_q),
    .rdata_o (ring_rdata)
  );

  // oldest sample leaving the window, zero before the first wrap
  logic [SONAR_W-1:0] old_left, old_right;
  logic [SUM_W-1:0]   sum_l_q, sum_r_q, sum_l_d, sum_r_d;

  always_comb begin
    if (s1_fwd_q) begin
      old_left  = fwd_left_q;
      old_right = fwd_right_q;
    end else if (s1_seen_q) begin
      old_left  = ring_rdata[2*SONAR_W-1:SONAR_W];
      old_right = ring_rdata[SONAR_W-1:0];
    end else begin
      old_left  = '0;
      old_right = '0;
    end
  end

  // running window sums
  assign sum_l_d = sum_l_q - SUM_W'(old_left) + SUM_W'(s1_left_q);
  assign sum_r_d = sum_r_q - SUM_W'(old_right) + SUM_W'(s1_right_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_l_q <= '0;
      sum_r_q <= '0;
    end else if (commit) begin
      sum_l_q <= sum_l_d;
      sum_r_q <= sum_r_d;
    end
  end

  // stage 2: window sums and magnetic readings
  logic [SUM_W-1:0] s2_sum_l_q, s2_sum_r_q;
  logic [MAG_W-1:0] s2_mag_l_q, s2_mag_r_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_en) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      s2_sum_l_q <= sum_l_d;
      s2_sum_r_q <= sum_r_d;
      s2_mag_l_q <= s1_mag_l_q;
      s2_mag_r_q <= s1_mag_r_q;
    end
  end

  // exact divide by the window length via reciprocal multiply
  logic [PROD_W-1:0]  prod_l, prod_r;
  logic [SONAR_W-1:0] mean_l, mean_r, clamp_l, clamp_r;

  assign prod_l = PROD_W'(s2_sum_l_q) * PROD_W'(RECIP_M);
  assign prod_r = PROD_W'(s2_sum_r_q) * PROD_W'(RECIP_M);
  assign mean_l = prod_l[DIV_SHIFT +: SONAR_W];
  assign mean_r = prod_r[DIV_SHIFT +: SONAR_W];

  // clamp to high first, then to low
  always_comb begin
    clamp_l = (mean_l >= clamp_high_q) ? clamp_high_q : mean_l;
    clamp_l = (clamp_l <= clamp_low_q) ? clamp_low_q : clamp_l;
    clamp_r = (mean_r >= clamp_high_q) ? clamp_high_q : mean_r;
    clamp_r = (clamp_r <= clamp_low_q) ? clamp_low_q : clamp_r;
  end

  // side flag and saturated magnitude
  logic [MAG_W-1:0]  neg_l, neg_r;
  logic [MAGN_W-1:0] magn_l, magn_r;

  assign neg_l = '0 - s2_mag_l_q;
  assign neg_r = '0 - s2_mag_r_q;

  always_comb begin
    if (!s2_mag_l_q[MAG_W-1]) begin
      magn_l = s2_mag_l_q[MAGN_W-1:0];
    end else if (neg_l[MAG_W-1]) begin
      magn_l = MAGN_MAX;
    end else begin
      magn_l = neg_l[MAGN_W-1:0];
    end
    if (!s2_mag_r_q[MAG_W-1]) begin
      magn_r = s2_mag_r_q[MAGN_W-1:0];
    end else if (neg_r[MAG_W-1]) begin
      magn_r = MAGN_MAX;
    end else begin
      magn_r = neg_r[MAGN_W-1:0];
    end
  end

  // output register
  logic [SONAR_W-1:0] out_avg_l_q, out_avg_r_q;
  logic               out_side_l_q, out_side_r_q;
  logic [MAGN_W-1:0]  out_magn_l_q, out_magn_r_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_en) begin
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en && s2_valid_q) begin
      out_avg_l_q  <= clamp_l;
      out_avg_r_q  <= clamp_r;
      out_side_l_q <= s2_mag_l_q[MAG_W-1];
      out_side_r_q <= s2_mag_r_q[MAG_W-1];
      out_magn_l_q <= magn_l;
      out_magn_r_q <= magn_r;
    end
  end

  assign result_o.valid              = out_valid_q;
  assign result_o.sonar_left_avg_mm  = out_avg_l_q;
  assign result_o.sonar_right_avg_mm = out_avg_r_q;
  assign result_o.side_left          = out_side_l_q;
  assign result_o.magnitude_left     = out_magn_l_q;
  assign result_o.side_right         = out_side_r_q;
  assign result_o.magnitude_right    = out_magn_r_q;

  // pointer stays inside the window
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_q <= PTR_LAST)
    else $error("ring pointer beyond window");

  // wrap at the last slot returns to slot zero and marks the ring full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && ptr_q == PTR_LAST) |=> (ptr_q == '0 && wrapped_q))
    else $error("ring wrap mishandled");

  // running sums never exceed a window of full-scale samples
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sum_l_q <= SUM_W'(WINDOW_LEN * 65535)) && (sum_r_q <= SUM_W'(WINDOW_LEN * 65535)))
    else $error("running sum out of range");

  // forwarding only happens when consecutive items share one slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_fwd_q) |-> (WINDOW_LEN == 1))
    else $error("unexpected slot forwarding");

endmodule

[rtl/core/smac_ram.sv]
// generic single write port ram with registered read-first output
module smac_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 10
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                     wdata_i,
  input  logic                                 re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, returns the old word on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
